FILE: hdl/tlbpw_pkg.sv
// Shared widths, constants and state type of the TLB and page walk translator.
package tlbpw_pkg;

  // Fixed field widths of the request and the response
  localparam int unsigned VA_W   = 32;
  localparam int unsigned PHYS_W = 20;
  localparam int unsigned SEED_W = 16;

  // Victim frame LFSR: reset seed and Galois taps
  localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

  // Translator control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

FILE: hdl/tlbpw_if.sv
// Valid/ready channels for translation requests and responses.
interface tlbpw_req_if import tlbpw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VA_W-1:0] virt_addr;

  modport source (output valid, output virt_addr, input ready);
  modport sink   (input valid, input virt_addr, output ready);
endinterface

interface tlbpw_rsp_if import tlbpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PHYS_W-1:0] phys_addr;
  logic              page_fault;
  logic              tlb_hit;

  modport source (output valid, output phys_addr, output page_fault, output tlb_hit,
                  input ready);
  modport sink   (input valid, input phys_addr, input page_fault, input tlb_hit,
                  output ready);
endinterface

FILE: hdl/tlbpw_ram.sv
// Generic single-port synchronous RAM with registered read data.
module tlbpw_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on we_i; register the read data on re_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tlb_lru_page_walk_translator_unit.sv
// Top level: LRU TLB in front of a flat page table with demand frame allocation.
//
// Usage:
//   req_i carries one virtual address per request (valid/ready); rsp_o returns
//   one physical address with page fault and TLB hit flags per request, in order.
//   cfg_we_i/cfg_wdata_i write the victim seed, which loads the victim LFSR
//   (a zero seed loads 1). Write it only while no request is in flight.
// Sequence:
//   A request is accepted in the idle state; its page table entry is read in
//   the same cycle and the TLB is compared in the next, after which the
//   response is registered. A new request is accepted only in the idle state.
//   A fault after all frames are handed out first passes through the victim
//   pick (LFSR step, then modulo by frame count through a reciprocal
//   multiply) before the response is registered.
// Reset:
//   The TLB is emptied at once. The page table is then swept invalid, one
//   entry a cycle, over all 2**PAGE_NUM_BITS entries (1048576 by default); no
//   request is accepted during the sweep, seed writes are.
// Stall:
//   One output register holds the response. A new request is accepted while
//   it waits; the next one holds in the walk until the register is free.
module tlb_lru_page_walk_translator_unit import tlbpw_pkg::*; #(
  parameter int unsigned TLB_ENTRIES   = 16,
  parameter int unsigned PAGE_NUM_BITS = 20,
  parameter int unsigned FRAME_COUNT   = 256,
  parameter int unsigned OFFSET_WIDTH  = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tlbpw_req_if.sink         req_i,
  tlbpw_rsp_if.source       rsp_o,
  input  logic              cfg_we_i,
  input  logic [SEED_W-1:0] cfg_wdata_i
);

  localparam int unsigned SLOT_W   = $clog2(TLB_ENTRIES);
  localparam int unsigned FRAME_W  = $clog2(FRAME_COUNT);
  localparam int unsigned CNT_W    = $clog2(FRAME_COUNT + 1);
  localparam int unsigned PTE_W    = FRAME_W + 1;
  localparam int unsigned PT_DEPTH = 2 ** PAGE_NUM_BITS;
  localparam int unsigned EXT_W    = VA_W + OFFSET_WIDTH + PAGE_NUM_BITS;
  localparam int unsigned PROD_W   = SEED_W + 32;

  localparam logic [SLOT_W-1:0]        AGE_MAX     = SLOT_W'(TLB_ENTRIES - 1);
  localparam logic [CNT_W-1:0]         FRAME_LIMIT = CNT_W'(FRAME_COUNT);
  localparam logic [SEED_W-1:0]        DIVISOR     = SEED_W'(FRAME_COUNT);
  localparam longint unsigned          RECIP_L     = (64'd1 << 32) / FRAME_COUNT;
  localparam logic [31:0]              RECIP       = 32'(RECIP_L);
  localparam logic [PAGE_NUM_BITS-1:0] CLR_LAST    = '1;

  // Control state
  state_e                   state_q, state_d;
  logic [PAGE_NUM_BITS-1:0] clr_q;
  logic [SEED_W-1:0]        lfsr_q;
  logic [CNT_W-1:0]         next_free_q;
  logic                     rsp_valid_q;

  // Request and victim datapath
  logic [PAGE_NUM_BITS-1:0] page_q;
  logic [OFFSET_WIDTH-1:0]  offset_q;
  logic [PROD_W-1:0]        prod_q;
  logic [FRAME_W-1:0]       victim_q;
  logic [PHYS_W-1:0]        phys_q;
  logic                     fault_q;
  logic                     hit_q;

  // TLB entries
  logic                     tlb_valid_q [TLB_ENTRIES];
  logic [PAGE_NUM_BITS-1:0] tlb_page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0]       tlb_frame_q [TLB_ENTRIES];
  logic [SLOT_W-1:0]        tlb_age_q   [TLB_ENTRIES];

  // Page table port
  logic                     ram_we;
  logic                     ram_re;
  logic [PAGE_NUM_BITS-1:0] ram_addr;
  logic [PTE_W-1:0]         ram_wdata;
  logic [PTE_W-1:0]         ram_rdata;

  logic [EXT_W-1:0]         va_ext;
  logic [PAGE_NUM_BITS-1:0] in_page;
  logic                     slot_free;
  logic                     hit_any;
  logic [SLOT_W-1:0]        hit_idx;
  logic                     free_any;
  logic [SLOT_W-1:0]        free_idx;
  logic [SLOT_W-1:0]        lru_idx;
  logic [SLOT_W-1:0]        touch_idx;
  logic [SLOT_W-1:0]        age_limit;
  logic [SEED_W-1:0]        lfsr_next;
  logic [SEED_W-1:0]        quot_frame;
  logic [SEED_W-1:0]        rem_raw;
  logic [SEED_W-1:0]        rem_fix;
  logic [FRAME_W-1:0]       res_frame;
  logic                     res_fault;
  logic                     finish;
  logic                     lfsr_step;
  logic                     alloc_inc;

  // Split the virtual address
  assign va_ext  = EXT_W'(req_i.virt_addr);
  assign in_page = va_ext[OFFSET_WIDTH +: PAGE_NUM_BITS];

  assign slot_free = !rsp_valid_q || rsp_o.ready;

  // Step the victim LFSR once
  assign lfsr_next = {1'b0, lfsr_q[SEED_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

  // Finish the modulo: quotient estimate is low by at most one
  assign quot_frame = SEED_W'(prod_q[PROD_W-1:32] * DIVISOR);
  assign rem_raw    = lfsr_q - quot_frame;
  assign rem_fix    = (rem_raw >= DIVISOR) ? (rem_raw - DIVISOR) : rem_raw;

  // Compare all TLB entries and choose the refill slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit_any && tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
    for (int i = 1; i < TLB_ENTRIES; i++) begin
      if (!free_any && !tlb_valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    // Ages of a full TLB are a permutation, so the oldest has the top rank
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_age_q[i] == AGE_MAX) begin
        lru_idx = SLOT_W'(i);
      end
    end
    priority if (hit_any) begin
      touch_idx = hit_idx;
    end else if (free_any) begin
      touch_idx = free_idx;
    end else if (!tlb_valid_q[0]) begin
      touch_idx = '0;
    end else begin
      touch_idx = lru_idx;
    end
    age_limit = tlb_valid_q[touch_idx] ? tlb_age_q[touch_idx] : AGE_MAX;
  end

  // Sequence the clear sweep, lookup, walk and victim pick
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = page_q;
    req_i.ready = 1'b0;
    res_frame = ram_rdata[FRAME_W-1:0];
    res_fault = 1'b0;
    finish    = 1'b0;
    lfsr_step = 1'b0;
    alloc_inc = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        ram_addr    = in_page;
        if (req_i.valid) begin
          ram_re  = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (hit_any) begin
          res_frame = tlb_frame_q[hit_idx];
          finish    = slot_free;
        end else if (ram_rdata[PTE_W-1]) begin
          finish = slot_free;
        end else if (next_free_q < FRAME_LIMIT) begin
          res_frame = next_free_q[FRAME_W-1:0];
          res_fault = 1'b1;
          finish    = slot_free;
          ram_we    = slot_free;
          alloc_inc = slot_free;
        end else begin
          lfsr_step = 1'b1;
          state_d   = ST_DIV;
        end
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        res_frame = victim_q;
        res_fault = 1'b1;
        finish    = slot_free;
        ram_we    = slot_free;
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Mark the entry valid on allocation; the sweep writes zero
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, res_frame};

  tlbpw_ram #(
    .WIDTH (PTE_W),
    .DEPTH (PT_DEPTH)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Advance control state, allocator and victim LFSR
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      lfsr_q      <= SEED_RESET;
      next_free_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        lfsr_q <= (cfg_wdata_i == '0) ? SEED_W'(1) : cfg_wdata_i;
      end else if (lfsr_step) begin
        lfsr_q <= lfsr_next;
      end
      if (alloc_inc) begin
        next_free_q <= next_free_q + 1'b1;
      end
      if (finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Update TLB valid bits and ages on completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid_q[i] <= 1'b0;
        tlb_age_q[i]   <= '0;
      end
    end else if (finish) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (SLOT_W'(i) == touch_idx) begin
          tlb_valid_q[i] <= 1'b1;
          tlb_age_q[i]   <= '0;
        end else if (tlb_valid_q[i] && (tlb_age_q[i] < age_limit)) begin
          tlb_age_q[i] <= tlb_age_q[i] + 1'b1;
        end
      end
    end
  end

  // Capture request, victim product and frame, response payload and TLB refill
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      page_q   <= in_page;
      offset_q <= va_ext[OFFSET_WIDTH-1:0];
    end
    if (lfsr_step) begin
      prod_q <= {32'b0, lfsr_next} * {SEED_W'(0), RECIP};
    end
    if (state_q == ST_DIV) begin
      victim_q <= FRAME_W'(rem_fix);
    end
    if (finish) begin
      phys_q  <= PHYS_W'({res_frame, offset_q});
      fault_q <= res_fault;
      hit_q   <= hit_any;
      if (!hit_any) begin
        tlb_page_q[touch_idx]  <= page_q;
        tlb_frame_q[touch_idx] <= res_frame;
      end
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.phys_addr  = phys_q;
  assign rsp_o.page_fault = fault_q;
  assign rsp_o.tlb_hit    = hit_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the LRU TLB and page walk translator.
import tlbpw_pkg::*;

typedef struct packed {
  logic [PHYS_W-1:0] phys_addr;
  logic              page_fault;
  logic              tlb_hit;
} xlat_t;

class tlb_shadow;
  localparam int SLOTS       = 16;
  localparam int FRAMES      = 256;
  localparam int SHOW_ERRORS = 20;

  // Shadow copy of the TLB, the page table and the frame allocator
  bit              slot_valid[SLOTS];
  bit [19:0]       slot_page[SLOTS];
  bit [7:0]        slot_frame[SLOTS];
  bit [3:0]        slot_age[SLOTS];
  bit [7:0]        page_map[bit [19:0]];
  int unsigned     frames_given;
  bit [SEED_W-1:0] lfsr;

  xlat_t       pending_xlat[$];
  int unsigned mismatches;
  int unsigned requests, hits, faults, victims;

  function new();
    lfsr = SEED_RESET;
  endfunction

  // A zero seed loads 1 so the LFSR never locks up
  function void load_seed(logic [SEED_W-1:0] seed);
    lfsr = (seed == '0) ? 16'd1 : seed;
  endfunction

  // Make slot s the youngest; age every valid entry younger than it was
  function void age_slots(int s);
    int limit;
    limit = slot_valid[s] ? int'(slot_age[s]) : SLOTS - 1;
    for (int j = 0; j < SLOTS; j++) begin
      if (j != s && slot_valid[j] && int'(slot_age[j]) < limit)
        slot_age[j] = slot_age[j] + 4'd1;
    end
    slot_age[s] = 4'd0;
  endfunction

  // First free slot among 1..15, then slot 0, else the oldest slot
  function int refill_slot();
    int best;
    best = 0;
    for (int i = 1; i < SLOTS; i++)
      if (!slot_valid[i]) return i;
    if (!slot_valid[0]) return 0;
    for (int i = 1; i < SLOTS; i++)
      if (slot_age[i] > slot_age[best]) best = i;
    return best;
  endfunction

  // Hand out frames in order, then draw victims from the LFSR
  function bit [7:0] grab_frame();
    bit lsb;
    bit [7:0] f;
    if (frames_given < FRAMES) begin
      f = 8'(frames_given);
      frames_given++;
    end else begin
      lsb  = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ LFSR_TAPS;
      f = lfsr[7:0];
      victims++;
    end
    return f;
  endfunction

  // Translate one accepted request and queue the expected response
  function void take_request(logic [VA_W-1:0] va);
    bit [19:0] page;
    bit [11:0] offs;
    bit [7:0]  frame;
    xlat_t     x;
    int        slot;
    page  = va[31:12];
    offs  = va[11:0];
    x     = '0;
    slot  = -1;
    frame = '0;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && slot_valid[i] && slot_page[i] == page) slot = i;
    if (slot >= 0) begin
      frame = slot_frame[slot];
      x.tlb_hit = 1'b1;
      age_slots(slot);
      hits++;
    end else begin
      if (page_map.exists(page)) begin
        frame = page_map[page];
      end else begin
        x.page_fault = 1'b1;
        frame = grab_frame();
        page_map[page] = frame;
        faults++;
      end
      slot = refill_slot();
      age_slots(slot);
      slot_valid[slot] = 1'b1;
      slot_page[slot]  = page;
      slot_frame[slot] = frame;
    end
    x.phys_addr = {frame, offs};
    pending_xlat.insert(pending_xlat.size(), x);
    requests++;
  endfunction

  task report(string what);
    if (mismatches < SHOW_ERRORS) $display("mismatch: %s", what);
    mismatches++;
  endtask

  // Compare one response with the oldest outstanding translation
  task match_response(xlat_t got);
    xlat_t want;
    if (pending_xlat.size() == 0) begin
      report($sformatf("response phys %h with no request outstanding", got.phys_addr));
      return;
    end
    want = pending_xlat.pop_front();
    if (got.phys_addr !== want.phys_addr)
      report($sformatf("phys_addr %h, expected %h", got.phys_addr, want.phys_addr));
    if (got.page_fault !== want.page_fault)
      report($sformatf("page_fault %b, expected %b (phys %h)", got.page_fault,
                       want.page_fault, want.phys_addr));
    if (got.tlb_hit !== want.tlb_hit)
      report($sformatf("tlb_hit %b, expected %b (phys %h)", got.tlb_hit,
                       want.tlb_hit, want.phys_addr));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int          HOT_PAGES   = 20;
  localparam int          SETTLE      = 8;
  localparam int          HOLD_CYCLES = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [SEED_W-1:0] cfg_wdata = '0;

  tlbpw_req_if req ();
  tlbpw_rsp_if rsp ();

  tlb_shadow   board;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_ask = 1'b0;
  int unsigned cycle_count = 0;
  logic [19:0] hot_pages[HOT_PAGES];
  logic [19:0] seen_pages[$];

  tlb_lru_page_walk_translator_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               board.pending_xlat.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Check responses; stall at random or hold off for a long stretch on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        board.match_response({rsp.phys_addr, rsp.page_fault, rsp.tlb_hit});
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one address, idling first at random, and wait until it is taken
  task automatic send_addr(input logic [VA_W-1:0] va);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.virt_addr <= va;
    do @(posedge clk); while (req.ready !== 1'b1);
    board.take_request(va);
  endtask

  // Drop valid and wait until every response is back and the block settles
  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending_xlat.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SEED_W-1:0] seed);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.load_seed(seed);
  endtask

  // A hot working set a bit larger than the TLB, mixed with revisits and fresh pages
  function automatic logic [VA_W-1:0] next_addr();
    int unsigned roll;
    logic [19:0] page;
    roll = $urandom_range(99);
    if ($urandom_range(49) == 0) hot_pages[$urandom_range(HOT_PAGES - 1)] = 20'($urandom);
    if (roll < 45)
      page = hot_pages[$urandom_range(HOT_PAGES - 1)];
    else if (roll < 65 && seen_pages.size() != 0)
      page = seen_pages[$urandom_range(seen_pages.size() - 1)];
    else
      page = 20'($urandom);
    seen_pages.insert(seen_pages.size(), page);
    return {page, 12'($urandom)};
  endfunction

  task automatic run_phase(input logic [SEED_W-1:0] seed, input int unsigned sgap,
                           input int unsigned rstall, input int count, input bit squeeze);
    write_seed(seed);
    send_gap_pct   = sgap;
    recv_stall_pct = rstall;
    if (squeeze) hold_ask = 1'b1;
    repeat (count) send_addr(next_addr());
    drain();
  endtask

  initial begin
    logic [VA_W-1:0] probes[$];
    logic [SEED_W-1:0] last_seed;
    req.valid     <= 1'b0;
    req.virt_addr <= '0;
    board = new();
    for (int i = 0; i < HOT_PAGES; i++) hot_pages[i] = 20'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: address extremes, hits, fill the TLB and evict the LRU entries,
    // then revisit an evicted page that is still mapped
    probes = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0FFF, 32'hFFFF_F000};
    for (int p = 1; p <= 16; p++) probes.insert(probes.size(), {20'(p), 12'h800});
    probes.insert(probes.size(), 32'h0000_0123);
    probes.insert(probes.size(), 32'h0000_0ABC);
    probes.insert(probes.size(), 32'h8000_0001);
    foreach (probes[i]) send_addr(probes[i]);
    drain();

    // Random phases under different seeds and idling patterns
    last_seed = 16'($urandom);
    run_phase(16'd1, 29, 67, 600, 1'b0);
    run_phase(16'hFFFF, 67, 29, 600, 1'b0);
    run_phase(16'd0, 0, 0, 400, 1'b1);
    run_phase(last_seed, 0, 0, 400, 1'b0);

    $display("covered %0d requests: %0d TLB hits, %0d page faults, %0d victim frames drawn",
             board.requests, board.hits, board.faults, board.victims);
    $display("seeds: reset value, 1, 65535, 0 and %h; one long response hold-off",
             last_seed);
    if (board.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
